// File: rtl/chb_pkg.sv
package chb_pkg;

    // number of buckets with a finite bound, and counter / value widths
    localparam int FINITE_BOUNDS = 7;
    localparam int COUNT_WIDTH   = 32;
    localparam int VALUE_WIDTH   = 32;

    // fixed field widths
    localparam int REG_COUNT   = 7;
    localparam int IDX_W       = 3;
    localparam int VAL_FIELD_W = 32;
    localparam int OUT_COUNT_W = 32;
    localparam int SUM_W       = 48;
    localparam int CFG_W       = 32;

    // significant bits of an observed value
    localparam int VAL_W = (VALUE_WIDTH < VAL_FIELD_W) ? VALUE_WIDTH : VAL_FIELD_W;

    // one read out gives every bucket and then the sum
    localparam int RESULTS = FINITE_BOUNDS + 2;
    localparam int CNT_W   = $clog2(RESULTS + 1);

    // output tdata: bucket_index, bucket_count, total_sum, padded to bytes
    localparam int OUT_RAW_W  = IDX_W + OUT_COUNT_W + SUM_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // operation codes on the input tuser
    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_READOUT = 1'b1;

    // result kind codes on the output tuser
    localparam logic KIND_COUNT = 1'b0;
    localparam logic KIND_SUM   = 1'b1;

    // bound registers after reset, Q15.16
    localparam logic signed [CFG_W-1:0] BOUND_RESET [REG_COUNT] = '{
        32'sd328, 32'sd1638, 32'sd6554, 32'sd32768,
        32'sd65536, 32'sd163840, 32'sd655360
    };

    typedef logic signed [VAL_FIELD_W-1:0] value_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;
    typedef logic [OUT_COUNT_W-1:0]        snap_t;
    typedef logic signed [SUM_W-1:0]       sum_t;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic observe;
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

// File: rtl/chb_cell.sv
module chb_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  chb_pkg::cell_ctl_t ctl,
    input  chb_pkg::value_t    value,
    input  chb_pkg::value_t    bound,
    input  logic               force_hit,
    input  chb_pkg::snap_t     shift_in,
    output chb_pkg::snap_t     shift_out
);
    import chb_pkg::*;

    count_t count_reg;
    count_t count_next;
    snap_t  snap_reg;
    snap_t  snap_next;
    logic   hit;
    logic   count_full;
    logic   count_wide;
    snap_t  count_clamped;

    // bucket hit when the value is at most the bound
    assign hit        = force_hit || (value <= bound);
    assign count_full = (count_reg == '1);

    // saturating counter
    always_comb
    begin
        count_next = count_reg;
        if (ctl.observe && hit && !count_full)
        begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
    end

    // counts wider than the output field read out as all ones
    assign count_wide    = (count_reg > COUNT_WIDTH'(32'hFFFF_FFFF));
    assign count_clamped = count_wide ? '1 : OUT_COUNT_W'(count_reg);

    // snapshot stage, loaded on read out, then shifted toward the output
    always_comb
    begin
        snap_next = snap_reg;
        if (ctl.load)
        begin
            snap_next = count_clamped;
        end
        else if (ctl.shift)
        begin
            snap_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

    assign shift_out = snap_reg;

endmodule

// File: rtl/chb_sum.sv
module chb_sum (
    input  logic               clk,
    input  logic               rst_n,
    input  chb_pkg::cell_ctl_t ctl,
    input  chb_pkg::value_t    value,
    output chb_pkg::sum_t      sum_snap
);
    import chb_pkg::*;

    sum_t                sum_reg;
    sum_t                sum_next;
    sum_t                snap_reg;
    logic signed [SUM_W:0] wide_sum;

    // one guard bit catches overflow of the running sum
    assign wide_sum = {sum_reg[SUM_W-1], sum_reg} + (SUM_W + 1)'(value);

    // clamp to the signed 48-bit range
    always_comb
    begin
        sum_next = sum_reg;
        if (ctl.observe)
        begin
            if (wide_sum[SUM_W] != wide_sum[SUM_W-1])
            begin
                sum_next = wide_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                           : {1'b0, {(SUM_W-1){1'b1}}};
            end
            else
            begin
                sum_next = wide_sum[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    // sum held for the end of a read out
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            snap_reg <= sum_reg;
        end
    end

    assign sum_snap = snap_reg;

endmodule

// File: rtl/cumulative_bucket_histogram_core.sv
// Cumulative bucket histogram with saturating counters and a saturating sum.
// Input stream: tuser is the operation (observe or read out), tdata is the
// observed value, signed Q15.16. While the row is idle an observe word is
// taken every cycle; each bucket cell compares the value with its bound and
// bumps its counter, the last cell always counts, and the sum unit adds the
// value, all at once. A read out word copies every counter into the snapshot
// stages of the cell row and the sum into the snapshot of the sum unit. The
// row then shifts one stage a cycle, while the output is not stalled, toward
// the output register: one word per bucket in order, then the sum word with
// tlast high. The first result word reaches the output register from the
// head of the row after the snapshot is loaded. While that row drains no new
// input word is taken; the next one is taken in the cycle the sum word moves
// to the output. A stalled output holds its word and the row waits behind it.
// Configuration: cfg_we writes cfg_data into bound register cfg_index;
// indexes past the last bound are ignored. Write only while idle.
// Reset (rst_n low) clears all counters and the sum, empties the row and
// loads the default bounds.
module cumulative_bucket_histogram_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // input words
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [chb_pkg::VAL_FIELD_W-1:0]    s_axis_tdata,  // observed_value
    input  logic                               s_axis_tuser,  // operation
    // result words
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // bucket_index [2:0], bucket_count [34:3], total_sum [82:35], zero pad
    output logic [chb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tuser,  // item_kind
    output logic                               m_axis_tlast,  // last_item
    // configuration
    input  logic                               cfg_we,
    input  logic [chb_pkg::IDX_W-1:0]          cfg_index,
    input  logic [chb_pkg::CFG_W-1:0]          cfg_data
);
    import chb_pkg::*;

    value_t             bound_reg [FINITE_BOUNDS];
    value_t             value;
    cell_ctl_t          ctl;
    snap_t              chain [FINITE_BOUNDS+2];
    sum_t               sum_snap;

    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               advance;
    logic               accept;
    logic               readout;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_kind_reg;
    logic [IDX_W-1:0]   out_index_reg;
    snap_t              out_count_reg;
    sum_t               out_sum_reg;
    logic               out_last_reg;

    // bound registers
    for (genvar k = 0; k < FINITE_BOUNDS; k++)
    begin : g_bound
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                bound_reg[k] <= BOUND_RESET[k];
            end
            else if (cfg_we && (cfg_index == IDX_W'(k)))
            begin
                bound_reg[k] <= cfg_data;
            end
        end
    end

    // input handshake and row control
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && advance);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign readout       = accept && (s_axis_tuser == OP_READOUT);

    assign value = VAL_FIELD_W'(signed'(s_axis_tdata[VAL_W-1:0]));

    assign ctl.observe = accept && (s_axis_tuser == OP_OBSERVE);
    assign ctl.load    = readout;
    assign ctl.shift   = advance && (cnt_reg > CNT_W'(1));

    // row of bucket cells, the infinite bucket last
    for (genvar k = 0; k <= FINITE_BOUNDS; k++)
    begin : g_cell
        chb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .value     (value),
            .bound     ((k < FINITE_BOUNDS) ? bound_reg[(k < FINITE_BOUNDS) ? k : 0]
                                            : value),
            .force_hit ((k == FINITE_BOUNDS) ? 1'b1 : 1'b0),
            .shift_in  (chain[k+1]),
            .shift_out (chain[k])
        );
    end

    // nothing feeds the tail of the row
    assign chain[FINITE_BOUNDS+1] = '0;

    chb_sum u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .value    (value),
        .sum_snap (sum_snap)
    );

    // words left in the row
    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = (cnt_reg != '0);
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
        if (readout)
        begin
            cnt_next = CNT_W'(RESULTS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register, loaded from the head of the row
    always_ff @(posedge clk)
    begin
        if (advance && (cnt_reg != '0))
        begin
            if (cnt_reg == CNT_W'(1))
            begin
                out_kind_reg  <= KIND_SUM;
                out_index_reg <= '0;
                out_count_reg <= '0;
                out_sum_reg   <= sum_snap;
                out_last_reg  <= 1'b1;
            end
            else
            begin
                out_kind_reg  <= KIND_COUNT;
                out_index_reg <= IDX_W'(CNT_W'(RESULTS) - cnt_reg);
                out_count_reg <= chain[0];
                out_sum_reg   <= '0;
                out_last_reg  <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_sum_reg, out_count_reg, out_index_reg});

endmodule

// File: dv/cumulative_bucket_histogram_core_test.sv
module cumulative_bucket_histogram_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import chb_pkg::*;

    // one result word split into its fields
    typedef struct packed {
        logic                          kind;
        logic [IDX_W-1:0]              bucket;
        logic [OUT_COUNT_W-1:0]        tally;
        logic signed [SUM_W-1:0]       total;
        logic                          last_flag;
    } hist_word_t;

    // bucket counters, running sum and the words a read out must produce
    class histogram_scoreboard;
        logic signed [CFG_W-1:0] bound [REG_COUNT];
        count_t                  tally [FINITE_BOUNDS+1];
        longint                  running_sum;
        hist_word_t              due_words [$];
        int                      failures;
        int                      observes;
        int                      readouts;
        int                      checked;
        int                      writes;

        function new();
            foreach (bound[i])
                bound[i] = BOUND_RESET[i];
            foreach (tally[i])
                tally[i] = '0;
            running_sum = 0;
        endfunction

        function void write_bound(int unsigned index, logic [CFG_W-1:0] data);
            writes++;
            // indexes past the last bound are dropped by the block
            if (index < REG_COUNT)
                bound[index] = data;
        endfunction

        // saturating counter increment
        function void bump(int i);
            if (tally[i] != {COUNT_WIDTH{1'b1}})
                tally[i] = tally[i] + 1'b1;
        endfunction

        function void note_word(logic op, logic [VAL_FIELD_W-1:0] value);
            logic signed [VAL_FIELD_W-1:0] v;
            longint                        next_sum;
            longint                        sum_top;
            logic [63:0]                   wide;
            hist_word_t                    w;
            sum_top = (longint'(1) <<< (SUM_W - 1)) - 1;
            if (op == OP_OBSERVE)
            begin
                observes++;
                // sign extend from the significant value bits
                v = value << (VAL_FIELD_W - VAL_W);
                v = v >>> (VAL_FIELD_W - VAL_W);
                for (int i = 0; i < FINITE_BOUNDS; i++)
                    if (v <= bound[i])
                        bump(i);
                bump(FINITE_BOUNDS);
                next_sum = running_sum + longint'(v);
                if (next_sum > sum_top)
                    next_sum = sum_top;
                if (next_sum < -sum_top - 1)
                    next_sum = -sum_top - 1;
                running_sum = next_sum;
            end
            else
            begin
                readouts++;
                // every bucket in order, clamped to the output count width
                for (int i = 0; i <= FINITE_BOUNDS; i++)
                begin
                    wide = 64'(tally[i]);
                    w = '0;
                    w.kind = KIND_COUNT;
                    w.bucket = IDX_W'(i);
                    w.tally = (wide > 64'hFFFF_FFFF) ? '1 : wide[OUT_COUNT_W-1:0];
                    due_words = {due_words, w};
                end
                // then the sum, marked last
                w = '0;
                w.kind = KIND_SUM;
                w.total = running_sum[SUM_W-1:0];
                w.last_flag = 1'b1;
                due_words = {due_words, w};
            end
        endfunction

        function void check_word(hist_word_t got);
            hist_word_t want;
            checked++;
            if (due_words.size() == 0)
            begin
                if (failures < 10)
                    $display("unexpected result word: kind %0d bucket %0d count %0d sum %0d last %0d",
                             got.kind, got.bucket, got.tally, got.total, got.last_flag);
                failures++;
            end
            else
            begin
                want = due_words.pop_front();
                if (got.kind !== want.kind || got.bucket !== want.bucket ||
                    got.tally !== want.tally || got.total !== want.total ||
                    got.last_flag !== want.last_flag)
                begin
                    if (failures < 10)
                    begin
                        $display("mismatch: expected kind %0d bucket %0d count %0d sum %0d last %0d",
                                 want.kind, want.bucket, want.tally, want.total, want.last_flag);
                        $display("          actual   kind %0d bucket %0d count %0d sum %0d last %0d",
                                 got.kind, got.bucket, got.tally, got.total, got.last_flag);
                    end
                    failures++;
                end
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [VAL_FIELD_W-1:0]  s_axis_tdata = '0;
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    cfg_we = 1'b0;
    logic [IDX_W-1:0]        cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;

    histogram_scoreboard board = new();
    bit calm = 1'b0;      // no idling on either side
    bit hold_req = 1'b0;  // ask the receiver for a long hold-off

    cumulative_bucket_histogram_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // watchdog
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: check accepted words, stall at random or on request
    initial
    begin
        int         hold_left;
        bit         hold_done;
        hist_word_t got;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready)
            begin
                got.kind = m_axis_tuser;
                got.bucket = m_axis_tdata[IDX_W-1:0];
                got.tally = m_axis_tdata[IDX_W +: OUT_COUNT_W];
                got.total = m_axis_tdata[IDX_W+OUT_COUNT_W +: SUM_W];
                got.last_flag = m_axis_tlast;
                board.check_word(got);
            end
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    // offer one word and wait until the block takes it
    task automatic send_word(input logic op, input logic [VAL_FIELD_W-1:0] value);
        if (!calm && $urandom_range(0, 99) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_word(op, value);
    endtask

    // stop sending and let every expected word come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.due_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input int unsigned index, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index[IDX_W-1:0];
        cfg_data <= data;
        @(posedge clk);
        board.write_bound(index, data);
    endtask

    task automatic load_bounds(input logic [CFG_W-1:0] vals [REG_COUNT]);
        for (int i = 0; i < REG_COUNT; i++)
            write_reg(i, vals[i]);
        cfg_we <= 1'b0;
    endtask

    // observed values biased toward bounds, extremes and the usual range
    function automatic logic [VAL_FIELD_W-1:0] pick_value();
        int k;
        k = $urandom_range(0, REG_COUNT - 1);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return board.bound[k] + $urandom_range(0, 4) - 2;
            2: return $urandom_range(0, 32'h0002_0000);
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            4: return -$urandom_range(0, 32'h0002_0000);
            default: return $urandom_range(0, 32'h0014_0000);
        endcase
    endfunction

    task automatic random_run(input int words);
        logic op;
        for (int n = 0; n < words; n++)
        begin
            op = ($urandom_range(0, 7) == 0) ? OP_READOUT : OP_OBSERVE;
            send_word(op, (op == OP_READOUT) ? $urandom : pick_value());
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] marks [REG_COUNT];
        logic [CFG_W-1:0] edges [12];

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default bounds: values on some bounds, just past some and far from all
        edges = '{32'd0, 32'd328, 32'd329, 32'd1638, 32'd1639, 32'd65536,
                  32'd655360, 32'd655361, 32'hFFFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'hAAAA_5555};
        send_word(OP_READOUT, 32'h0);
        foreach (edges[i])
            send_word(OP_OBSERVE, edges[i]);
        send_word(OP_READOUT, 32'h0);
        send_word(OP_READOUT, 32'hFFFF_FFFF);
        send_word(OP_OBSERVE, 32'd6554);
        send_word(OP_OBSERVE, 32'd32768);
        send_word(OP_OBSERVE, 32'd163840);
        send_word(OP_READOUT, 32'h5555_AAAA);
        settle();

        // extreme and unordered bounds, plus a write to a missing register
        marks = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                  32'd65536, 32'hFFFF_0000, 32'h7FFF_FFFF};
        load_bounds(marks);
        write_reg(REG_COUNT, $urandom);
        cfg_we <= 1'b0;
        // receiver holds off while reads pile up behind it
        hold_req = 1'b1;
        send_word(OP_READOUT, 32'h0);
        random_run(60);
        settle();

        // random bounds in any order
        foreach (marks[i])
            marks[i] = $urandom;
        load_bounds(marks);
        random_run(60);
        settle();

        // falling bounds, no idling until the final settle
        marks = '{32'd655360, 32'd163840, 32'd65536, 32'd32768,
                  32'd6554, 32'd1638, 32'd328};
        load_bounds(marks);
        calm = 1'b1;
        random_run(60);

        // large values of both signs on the running sum
        for (int n = 0; n < 3; n++)
            send_word(OP_OBSERVE, 32'h7FFF_FFFF);
        send_word(OP_READOUT, 32'h0);
        for (int n = 0; n < 6; n++)
            send_word(OP_OBSERVE, 32'h8000_0000);
        send_word(OP_READOUT, 32'h0);
        send_word(OP_OBSERVE, 32'h0001_0000);
        send_word(OP_READOUT, 32'h0);
        calm = 1'b0;
        settle();
        repeat (20) @(posedge clk);

        if (board.due_words.size() != 0)
        begin
            $display("%0d expected result words never arrived", board.due_words.size());
            board.failures += board.due_words.size();
        end
        $display("ran %0d observe and %0d read out words, %0d result words checked",
                 board.observes, board.readouts, board.checked);
        $display("%0d bound writes over four settings, large sums of both signs, %0d failures",
                 board.writes, board.failures);
        if (board.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/chb_pkg.sv
rtl/chb_cell.sv
rtl/chb_sum.sv
rtl/cumulative_bucket_histogram_core.sv
dv/cumulative_bucket_histogram_core_test.sv
